FILE: rtl/cdq_pkg.sv
// Shared types, constants and pointer helpers for the ring-buffer deque.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package cdq_pkg;

    localparam int DEPTH      = 8;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = (DEPTH > 2) ? $clog2(DEPTH) : 1;

    // Fixed field widths of the stream payloads.
    localparam int CMD_W      = 3;
    localparam int DIN_W      = 32;
    localparam int DOUT_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [PTR_W:0]        ptr_ext_t;
    typedef logic [DIN_W-1:0]      din_t;
    typedef logic [DOUT_W-1:0]     dout_t;
    typedef logic [COUNT_W-1:0]    count_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_REAR  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        FSM_IDLE   = 1'b0,
        FSM_RESULT = 1'b1
    } fsm_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic issue;     // take the command on the input and do the slot access
        logic load_out;  // move the pending result into the output register
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;  // output register is empty or being drained this cycle
    } dp_stat_t;

    function automatic ptr_t ptr_next(ptr_t p);
        ptr_t r;
        if (p == ptr_t'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

    function automatic ptr_t ptr_prev(ptr_t p);
        ptr_t r;
        if (p == '0) begin
            r = ptr_t'(DEPTH - 1);
        end else begin
            r = p - ptr_t'(1);
        end
        return r;
    endfunction

    // Number of entries between head and tail, modulo DEPTH.
    function automatic ptr_t ptr_dist(ptr_t t, ptr_t h);
        ptr_ext_t s;
        if (t >= h) begin
            s = {1'b0, t} - {1'b0, h};
        end else begin
            s = {1'b0, t} + ptr_ext_t'(DEPTH) - {1'b0, h};
        end
        return ptr_t'(s);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cdq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; holds the deque slots.
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                        aclk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/cdq_ctrl.sv
// Controller state machine of the deque: sequences command issue and result load.
// Depends on cdq_pkg for the state type and the command/status structs.
`default_nettype none

module cdq_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire cdq_pkg::dp_stat_t   stat,
    output cdq_pkg::ctrl_cmd_t       cmd
);

    cdq_pkg::fsm_state_t state_reg;
    cdq_pkg::fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cdq_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.issue    = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            cdq_pkg::FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.issue  = 1'b1;
                    state_next = cdq_pkg::FSM_RESULT;
                end
            end
            cdq_pkg::FSM_RESULT: begin
                // The slot read data is ready now; wait for room at the output.
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = cdq_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = cdq_pkg::FSM_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/cdq_dp.sv
// Datapath of the deque: head/tail pointers, slot RAM, pending result and
// output register. Depends on cdq_pkg and cdq_ram.
`default_nettype none

module cdq_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cdq_pkg::ctrl_cmd_t                cmd,
    output cdq_pkg::dp_stat_t                      stat,
    input  wire logic [cdq_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [cdq_pkg::M_TDATA_W-1:0]     m_tdata
);

    cdq_pkg::ptr_t    head_reg, head_next;
    cdq_pkg::ptr_t    tail_reg, tail_next;
    cdq_pkg::cmd_t    op;
    cdq_pkg::data_t   din;
    cdq_pkg::status_t op_status;
    logic             ring_empty, is_full;
    logic             op_we, op_re;
    cdq_pkg::ptr_t    waddr, raddr;
    cdq_pkg::data_t   rdata;

    cdq_pkg::status_t pend_status_reg;
    logic             pend_empty_reg, pend_full_reg, pend_rd_reg;
    cdq_pkg::ptr_t    pend_count_reg;

    logic             m_tvalid_reg;
    cdq_pkg::dout_t   out_data_reg;
    cdq_pkg::status_t out_status_reg;
    logic             out_empty_reg, out_full_reg;
    cdq_pkg::count_t  out_count_reg;

    assign op  = cdq_pkg::cmd_t'(s_tdata[cdq_pkg::CMD_W-1:0]);
    assign din = cdq_pkg::data_t'(s_tdata[cdq_pkg::CMD_W +: cdq_pkg::DIN_W]);

    assign ring_empty = (head_reg == tail_reg);
    assign is_full    = (cdq_pkg::ptr_next(tail_reg) == head_reg);

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        op_status = cdq_pkg::ST_OK;
        op_we     = 1'b0;
        op_re     = 1'b0;
        waddr     = head_reg;
        raddr     = cdq_pkg::ptr_next(head_reg);
        case (op)
            cdq_pkg::CMD_PUSH_FRONT: begin
                if (is_full) begin
                    op_status = cdq_pkg::ST_FULL;
                end else begin
                    op_we     = 1'b1;
                    waddr     = head_reg;
                    head_next = cdq_pkg::ptr_prev(head_reg);
                end
            end
            cdq_pkg::CMD_PUSH_REAR: begin
                if (is_full) begin
                    op_status = cdq_pkg::ST_FULL;
                end else begin
                    tail_next = cdq_pkg::ptr_next(tail_reg);
                    op_we     = 1'b1;
                    waddr     = cdq_pkg::ptr_next(tail_reg);
                end
            end
            cdq_pkg::CMD_POP_FRONT: begin
                if (ring_empty) begin
                    op_status = cdq_pkg::ST_EMPTY;
                end else begin
                    head_next = cdq_pkg::ptr_next(head_reg);
                    op_re     = 1'b1;
                    raddr     = cdq_pkg::ptr_next(head_reg);
                end
            end
            cdq_pkg::CMD_POP_REAR: begin
                if (ring_empty) begin
                    op_status = cdq_pkg::ST_EMPTY;
                end else begin
                    op_re     = 1'b1;
                    raddr     = tail_reg;
                    tail_next = cdq_pkg::ptr_prev(tail_reg);
                end
            end
            cdq_pkg::CMD_PEEK_FRONT: begin
                if (ring_empty) begin
                    op_status = cdq_pkg::ST_EMPTY;
                end else begin
                    op_re = 1'b1;
                    raddr = cdq_pkg::ptr_next(head_reg);
                end
            end
            cdq_pkg::CMD_PEEK_REAR: begin
                if (ring_empty) begin
                    op_status = cdq_pkg::ST_EMPTY;
                end else begin
                    op_re = 1'b1;
                    raddr = tail_reg;
                end
            end
            default: begin
            end
        endcase
    end

    cdq_ram #(
        .WIDTH (cdq_pkg::DATA_WIDTH),
        .DEPTH (cdq_pkg::DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (cmd.issue & op_we),
        .waddr (waddr),
        .wdata (din),
        .re    (cmd.issue & op_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else if (cmd.issue) begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Everything but the slot data is known at issue; it waits here for the RAM read.
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            pend_status_reg <= op_status;
            pend_rd_reg     <= op_re;
            pend_empty_reg  <= (head_next == tail_next);
            pend_full_reg   <= (cdq_pkg::ptr_next(tail_next) == head_next);
            pend_count_reg  <= cdq_pkg::ptr_dist(tail_next, head_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg   <= pend_rd_reg ? cdq_pkg::dout_t'(rdata) : '0;
            out_status_reg <= pend_status_reg;
            out_empty_reg  <= pend_empty_reg;
            out_full_reg   <= pend_full_reg;
            out_count_reg  <= cdq_pkg::count_t'(pend_count_reg);
        end
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = {1'b0, out_count_reg, out_full_reg, out_empty_reg,
                            out_status_reg, out_data_reg};

    ap_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an unaccepted result");

    ap_ptrs_idle_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.issue |=> ($stable(head_reg) && $stable(tail_reg)))
        else $error("pointers moved without a command");

    ap_push_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.issue && op_we) |=> (head_reg != tail_reg))
        else $error("deque empty after a successful push");

    ap_pop_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.issue && op_re && (op == cdq_pkg::CMD_POP_FRONT || op == cdq_pkg::CMD_POP_REAR))
        |=> (cdq_pkg::ptr_next(tail_reg) != head_reg))
        else $error("deque full after a successful pop");

    ap_no_write_and_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> !(op_we && op_re))
        else $error("slot write and read in the same command");

endmodule

`default_nettype wire

FILE: rtl/circular_deque.sv
// Ring-buffer double-ended queue: one result transfer for every command transfer.
// The result passes through the registered slot read and the pending registers, then
// into the output register once that register is free or being drained. A new command
// is taken only after the result of the last one has gone to the output register.
// A waiting result does not block the next command; only the following result waits.
// Reset (aresetn low, synchronous) empties the deque; the slot RAM is not cleared.
// Depends on cdq_pkg, cdq_ctrl, cdq_dp and cdq_ram.
`default_nettype none

module circular_deque (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [2:0] cmd, [34:3] data_in, [39:35] zero
    input  wire logic [cdq_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] data_out, [33:32] status, [34] is_empty_now, [35] is_full_now,
    // [38:36] entry_count, [39] zero
    output logic      [cdq_pkg::M_TDATA_W-1:0]  m_tdata
);

    cdq_pkg::ctrl_cmd_t ctrl_cmd;
    cdq_pkg::dp_stat_t  dp_stat;

    cdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    cdq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (ctrl_cmd),
        .stat     (dp_stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
